// ===== sv/accelerometer_step_detector_macros.svh =====
// Assertion macros for the accelerometer step detector.
`ifndef ACCELEROMETER_STEP_DETECTOR_MACROS_SVH
`define ACCELEROMETER_STEP_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on rising clk while out of reset.
`define ASD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on rising clk while out of reset.
`define ASD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define ASD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/asd_pkg.sv =====
// Shared types and constants of the accelerometer step detector.
`default_nettype none

package asd_pkg;

  // Field widths
  localparam int unsigned AxisW    = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned MagW     = 16;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned ScaleW   = 10;
  localparam int unsigned FracW    = 8;
  localparam int unsigned FracSumW = 11;
  localparam int unsigned CountW   = 32;
  localparam int unsigned AddW     = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned SumW     = 32;

  // Stream payload widths
  localparam int unsigned InDataW  = 80;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned OutUserW = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_PERIOD_ON   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PERIOD_OFF  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HIGH_THR    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LOW_THR     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_COOLDOWN    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_REARM_QUIET = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_STEP_SCALE  = 3'd6;

  // Reset values
  localparam logic [CfgW-1:0]   RST_PERIOD_ON   = 16'd50;
  localparam logic [CfgW-1:0]   RST_PERIOD_OFF  = 16'd80;
  localparam logic [CfgW-1:0]   RST_HIGH_THR    = 16'd260;
  localparam logic [CfgW-1:0]   RST_LOW_THR     = 16'd220;
  localparam logic [CfgW-1:0]   RST_COOLDOWN    = 16'd320;
  localparam logic [CfgW-1:0]   RST_REARM_QUIET = 16'd40;
  localparam logic [ScaleW-1:0] RST_STEP_SCALE  = 10'd435;
  localparam logic [MagW-1:0]   RST_BASELINE    = 16'd1000;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  // Controller to datapath
  typedef struct packed {
    logic  drop;        // tracking off: forget baseline, re-arm
    logic  take;        // sample accepted: stamp time, clear sum
    logic  sq_en;       // accumulate square of sq_axis
    axis_e sq_axis;
    logic  root_start;  // launch square root of the sum
    logic  base;        // seed or update baseline
    logic  decide;      // re-arm / step decision
    logic  count;       // credit steps
    logic  emit;        // load result into output register
  } asd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sensor_ready;
    logic allowed;
    logic elapsed;
    logic root_done;
    logic base_valid;
    logic out_free;
  } asd_sts_t;

endpackage

`default_nettype wire

// ===== sv/asd_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
`default_nettype none

module asd_sqrt
  import asd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SumW-1:0]  radicand_i,
  output logic                  done_o,
  output logic [MagW-1:0]       root_o
);

  localparam int unsigned Iters = SumW / 2;
  localparam int unsigned CntW  = $clog2(Iters);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [SumW-1:0] rem_q, res_q, bit_q;
  logic [SumW-1:0] trial;
  logic            fits;

  // One trial subtraction per cycle
  assign trial = res_q + bit_q;
  assign fits  = rem_q >= trial;

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Iters - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder, partial root and trial bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= radicand_i;
      res_q <= '0;
      bit_q <= SumW'(1) << (SumW - 2);
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[MagW-1:0];

endmodule

`default_nettype wire

// ===== sv/asd_dp.sv =====
// Datapath: config registers, squares, baseline, step decision, count, output register.
`default_nettype none

module asd_dp
  import asd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_accept_i,
  input  wire logic [InDataW-1:0]   s_tdata_i,
  input  wire logic [InUserW-1:0]   s_tuser_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgW-1:0]      cfg_wdata_i,
  input  wire asd_cmd_t             cmd_i,
  output asd_sts_t                  sts_o,
  input  wire logic                 m_tready_i,
  output logic                      m_tvalid_o,
  output logic [OutDataW-1:0]       m_tdata_o,
  output logic [OutUserW-1:0]       m_tuser_o
);

  // Configuration
  logic [CfgW-1:0]   period_on_q, period_off_q, high_thr_q, low_thr_q;
  logic [CfgW-1:0]   cooldown_q, rearm_q;
  logic [ScaleW-1:0] scale_q;

  // Latched item
  logic signed [AxisW-1:0] ax_q, ay_q, az_q;
  logic [TimeW-1:0]        now_q;
  logic                    screen_q, allowed_q, ready_q;

  // Detector state
  logic [TimeW-1:0]  last_sample_q, last_step_q, quiet_q;
  logic [MagW-1:0]   baseline_q;
  logic              base_valid_q, armed_q;
  logic [FracW-1:0]  frac_q;
  logic [CountW-1:0] total_q;

  // Per-item working and result registers
  logic [SumW-1:0]     sum_q;
  logic [FracSumW-1:0] frac_sum_q;
  logic                taken_q, det_q;
  logic [AddW-1:0]     added_q;
  logic [MagW-1:0]     mag_q;

  // Output register
  logic                m_tvalid_q;
  logic [OutDataW-1:0] m_tdata_q;
  logic [OutUserW-1:0] m_tuser_q;

  logic                    root_done;
  logic [MagW-1:0]         root;
  logic [CfgW-1:0]         period;
  logic signed [AxisW-1:0] opnd;
  logic signed [SumW-1:0]  sq;
  logic [MagW+4:0]         base_acc;
  logic [MagW-1:0]         delta;
  logic [TimeW-1:0]        quiet_eff;
  logic                    quiet, rearm_ok, step_ok;
  logic [CountW:0]         tot_sum;

  asd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.root_start),
    .radicand_i (sum_q),
    .done_o     (root_done),
    .root_o     (root)
  );

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_on_q  <= RST_PERIOD_ON;
      period_off_q <= RST_PERIOD_OFF;
      high_thr_q   <= RST_HIGH_THR;
      low_thr_q    <= RST_LOW_THR;
      cooldown_q   <= RST_COOLDOWN;
      rearm_q      <= RST_REARM_QUIET;
      scale_q      <= RST_STEP_SCALE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PERIOD_ON:   period_on_q  <= cfg_wdata_i;
        REG_PERIOD_OFF:  period_off_q <= cfg_wdata_i;
        REG_HIGH_THR:    high_thr_q   <= cfg_wdata_i;
        REG_LOW_THR:     low_thr_q    <= cfg_wdata_i;
        REG_COOLDOWN:    cooldown_q   <= cfg_wdata_i;
        REG_REARM_QUIET: rearm_q      <= cfg_wdata_i;
        REG_STEP_SCALE:  scale_q      <= cfg_wdata_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // Gate checks on the latched item
  assign period = screen_q ? period_on_q : period_off_q;

  // Square of one axis per cycle
  always_comb begin
    unique case (cmd_i.sq_axis)
      AXIS_X:  opnd = ax_q;
      AXIS_Y:  opnd = ay_q;
      AXIS_Z:  opnd = az_q;
      default: opnd = ax_q;
    endcase
  end
  assign sq = SumW'(opnd) * SumW'(opnd);

  // Baseline moving average: (15 * old + mag) / 16
  assign base_acc = {1'b0, baseline_q, 4'b0} - {5'b0, baseline_q} + {5'b0, mag_q};

  // Deviation, quiet and step tests against the updated baseline
  assign delta     = (mag_q >= baseline_q) ? mag_q - baseline_q : baseline_q - mag_q;
  assign quiet     = delta <= low_thr_q;
  assign quiet_eff = (quiet_q == '0) ? now_q : quiet_q;
  assign rearm_ok  = (now_q - quiet_eff) >= {16'b0, rearm_q};
  assign step_ok   = (delta >= high_thr_q) &&
                     ((now_q - last_step_q) >= {16'b0, cooldown_q});

  // Saturating count update
  assign tot_sum = {1'b0, total_q} + {30'b0, frac_sum_q[FracSumW-1:FracW]};

  // Detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sample_q <= '0;
      last_step_q   <= '0;
      quiet_q       <= '0;
      baseline_q    <= RST_BASELINE;
      base_valid_q  <= 1'b0;
      armed_q       <= 1'b1;
      frac_q        <= '0;
      total_q       <= '0;
    end else begin
      if (cmd_i.drop) begin
        base_valid_q <= 1'b0;
        armed_q      <= 1'b1;
      end
      if (cmd_i.take) begin
        last_sample_q <= now_q;
      end
      if (cmd_i.base) begin
        base_valid_q <= 1'b1;
        baseline_q   <= base_valid_q ? base_acc[MagW+3:4] : mag_q;
      end
      if (cmd_i.decide) begin
        if (!armed_q) begin
          if (quiet) begin
            quiet_q <= quiet_eff;
            if (rearm_ok) begin
              armed_q <= 1'b1;
            end
          end else begin
            quiet_q <= '0;
          end
        end else if (step_ok) begin
          armed_q     <= 1'b0;
          quiet_q     <= '0;
          last_step_q <= now_q;
        end
      end
      if (cmd_i.count && det_q) begin
        frac_q  <= frac_sum_q[FracW-1:0];
        total_q <= tot_sum[CountW] ? '1 : tot_sum[CountW-1:0];
      end
    end
  end

  // Item latch, working and result registers
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      ax_q      <= s_tdata_i[15:0];
      ay_q      <= s_tdata_i[31:16];
      az_q      <= s_tdata_i[47:32];
      now_q     <= s_tdata_i[79:48];
      screen_q  <= s_tuser_i[0];
      allowed_q <= s_tuser_i[1];
      ready_q   <= s_tuser_i[2];
      taken_q   <= 1'b0;
      det_q     <= 1'b0;
      added_q   <= '0;
      mag_q     <= '0;
    end
    if (cmd_i.take) begin
      taken_q <= 1'b1;
      sum_q   <= '0;
    end
    if (cmd_i.sq_en) begin
      sum_q <= sum_q + sq;
    end
    if (root_done) begin
      mag_q <= root;
    end
    if (cmd_i.decide && armed_q && step_ok) begin
      det_q      <= 1'b1;
      frac_sum_q <= {3'b0, frac_q} + {1'b0, scale_q};
    end
    if (cmd_i.count && det_q) begin
      added_q <= frac_sum_q[FracSumW-1:FracW];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_tdata_q <= {5'b0, baseline_q, mag_q, total_q, added_q};
      m_tuser_q <= {det_q, taken_q};
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;

  // Status to controller
  assign sts_o.sensor_ready = ready_q;
  assign sts_o.allowed      = allowed_q;
  assign sts_o.elapsed      = (now_q - last_sample_q) >= {16'b0, period};
  assign sts_o.root_done    = root_done;
  assign sts_o.base_valid   = base_valid_q;
  assign sts_o.out_free     = !m_tvalid_q || m_tready_i;

endmodule

`default_nettype wire

// ===== sv/asd_ctrl.sv =====
// Controller: sequences gating, squares, root, baseline, decision, count and output.
`default_nettype none

module asd_ctrl
  import asd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_tvalid_i,
  output logic          s_tready_o,
  input  wire asd_sts_t sts_i,
  output asd_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GATE,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_ROOT,
    ST_WAIT,
    ST_BASE,
    ST_DECIDE,
    ST_COUNT,
    ST_EMIT
  } state_e;

  state_e   state_q;
  logic     tready_q;
  asd_cmd_t cmd_q;

  // State and registered commands; cmd_q is the work of the state being entered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tready_q <= 1'b1;
      cmd_q    <= '0;
    end else begin
      cmd_q <= '0;
      unique case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) begin
            tready_q <= 1'b0;
            state_q  <= ST_GATE;
          end
        end
        ST_GATE: begin
          priority if (!sts_i.sensor_ready) begin
            state_q <= ST_EMIT;
          end else if (!sts_i.allowed) begin
            cmd_q.drop <= 1'b1;
            state_q    <= ST_EMIT;
          end else if (!sts_i.elapsed) begin
            state_q <= ST_EMIT;
          end else begin
            cmd_q.take <= 1'b1;
            state_q    <= ST_SQ0;
          end
        end
        ST_SQ0: begin
          cmd_q.sq_en   <= 1'b1;
          cmd_q.sq_axis <= AXIS_X;
          state_q       <= ST_SQ1;
        end
        ST_SQ1: begin
          cmd_q.sq_en   <= 1'b1;
          cmd_q.sq_axis <= AXIS_Y;
          state_q       <= ST_SQ2;
        end
        ST_SQ2: begin
          cmd_q.sq_en   <= 1'b1;
          cmd_q.sq_axis <= AXIS_Z;
          state_q       <= ST_SQ3;
        end
        ST_SQ3: begin
          cmd_q.root_start <= 1'b1;
          state_q          <= ST_ROOT;
        end
        ST_ROOT: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (sts_i.root_done) begin
            cmd_q.base <= 1'b1;
            state_q    <= ST_BASE;
          end
        end
        ST_BASE: begin
          // first sample only seeds the baseline
          if (sts_i.base_valid) begin
            cmd_q.decide <= 1'b1;
            state_q      <= ST_DECIDE;
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_DECIDE: begin
          cmd_q.count <= 1'b1;
          state_q     <= ST_COUNT;
        end
        ST_COUNT: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (sts_i.out_free) begin
            cmd_q.emit <= 1'b1;
            tready_q   <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          tready_q <= 1'b1;
          state_q  <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready_o = tready_q;
  assign cmd_o      = cmd_q;

endmodule

`default_nettype wire

// ===== sv/accelerometer_step_detector.sv =====
// Top level of the accelerometer step detector.
//
//   channel  | dir | handshake                   | payload
//   ---------+-----+-----------------------------+-----------------------------------
//   s_axis   | in  | s_axis_tvalid/s_axis_tready | tdata 80b, tuser 3b flags
//   m_axis   | out | m_axis_tvalid/m_axis_tready | tdata 72b, tuser 2b flags
//   cfg      | in  | cfg_we_i (no wait)          | cfg_idx_i 3b, cfg_wdata_i 16b
//
// A taken sample is squared, passes the bit-per-cycle square root and updates
// the baseline; all but the first one, which only seeds the baseline, then go
// through the step decision and count. Gated items (sensor off, tracking off,
// period not elapsed) skip to the output. One item is worked on at a time.
// Async active-low reset restores control, config and state registers to defaults.
// A waiting result sits in the output register; the next item is accepted
// meanwhile and only its own result waits on m_axis_tready.
`default_nettype none
`include "accelerometer_step_detector_macros.svh"

module accelerometer_step_detector
  import asd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [79:48] now_ms
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // [0] screen_on, [1] tracking_allowed, [2] sensor_ready
  input  wire logic [InUserW-1:0]  s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [2:0] steps_added, [34:3] step_count, [50:35] magnitude_mg,
  // [66:51] baseline_level_mg, [71:67] zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  // [0] sample_taken, [1] step_detected
  output logic [OutUserW-1:0]      m_axis_tuser,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_wdata_i
);

  asd_cmd_t cmd;
  asd_sts_t sts;
  logic     in_accept;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  asd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  asd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

  // Checks
  `ASD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_accept, !s_axis_tready, "ready stayed high after accept")
  `ASD_ASSERT_NOW(a_step_needs_sample, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0], "step without sample")
  `ASD_ASSERT_NOW(a_added_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[2:0] <= 3'd4, "steps_added above four")
  `ASD_ASSERT_NOW(a_mag_zero_no_sample, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[50:35] == 16'd0, "magnitude without sample")

endmodule

`default_nettype wire
